// File: sv/ctv_pkg.sv
package ctv_pkg;

  // shared datapath width of the serial multiply and divide units
  localparam int CTV_DW = 48;

  localparam logic [15:0] RST_CURRENT_UA = 16'd1042;
  localparam logic [12:0] RST_REF_MV     = 13'd1100;
  localparam logic [12:0] RST_MIN_DELTA  = 13'd50;
  localparam logic [6:0]  RST_PLAUS_PCT  = 7'd15;
  localparam logic [31:0] RST_CAP_MIN    = 32'd10000;
  localparam logic [31:0] RST_CAP_MAX    = 32'd10000000;

  localparam logic [12:0] ADC_FULL_SCALE = 13'd1023;
  localparam logic [12:0] MEAN_OF_THREE  = 13'd3;

  localparam logic [31:0] SIZE_LIM0 = 32'd22000;
  localparam logic [31:0] SIZE_LIM1 = 32'd100000;
  localparam logic [31:0] SIZE_LIM2 = 32'd330000;
  localparam logic [31:0] SIZE_LIM3 = 32'd1000000;

  localparam logic [1:0] LAST_POS = 2'd2;

  typedef enum logic [2:0] {
    REG_CURRENT_UA = 3'd0,
    REG_REF_MV     = 3'd1,
    REG_MIN_DELTA  = 3'd2,
    REG_PLAUS_PCT  = 3'd3,
    REG_CAP_MIN    = 3'd4,
    REG_CAP_MAX    = 3'd5
  } ctv_reg_t;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_INVALID = 2'd1,
    ST_SCATTER = 2'd2,
    ST_PASS    = 2'd3
  } ctv_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SMV_MUL,
    S_SMV_DIV,
    S_VAL_MUL,
    S_VAL_DIV,
    S_AGR_START,
    S_AGR_WAIT,
    S_MEAN_DIV,
    S_FIN
  } ctv_state_t;

  typedef struct packed {
    logic       start;
    logic [4:0] nbits;
  } ctv_mul_req_t;

  typedef struct packed {
    logic       start;
    logic [5:0] nbits;
  } ctv_div_req_t;

endpackage

// File: sv/ctv_mul.sv
module ctv_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctv_pkg::ctv_mul_req_t      req,
  input  logic [31:0]                a,
  input  logic [15:0]                b,
  output logic                       done,
  output logic [ctv_pkg::CTV_DW-1:0] prod
);
  import ctv_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [4:0]        cnt_r;
  logic [CTV_DW-1:0] acc_r;
  logic [CTV_DW-1:0] a_sh_r;
  logic [15:0]       b_sh_r;

  // shift-add, one multiplier bit per cycle, LSB first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r  <= '0;
      a_sh_r <= {{(CTV_DW-32){1'b0}}, a};
      b_sh_r <= b;
    end else if (busy_r) begin
      if (b_sh_r[0]) acc_r <= acc_r + a_sh_r;
      a_sh_r <= {a_sh_r[CTV_DW-2:0], 1'b0};
      b_sh_r <= {1'b0, b_sh_r[15:1]};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: sv/ctv_div.sv
module ctv_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctv_pkg::ctv_div_req_t      req,
  input  logic [ctv_pkg::CTV_DW-1:0] dividend,  // left aligned, nbits significant
  input  logic [12:0]                divisor,
  output logic                       done,
  output logic [ctv_pkg::CTV_DW-1:0] quotient
);
  import ctv_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [5:0]        cnt_r;
  logic [12:0]       rem_r;
  logic [12:0]       dvs_r;
  logic [CTV_DW-1:0] dvd_r;
  logic [CTV_DW-1:0] q_r;
  logic [13:0]       trial;
  logic              ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, dvd_r[CTV_DW-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      dvd_r <= dividend;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? 13'(trial - {1'b0, dvs_r}) : trial[12:0];
      dvd_r <= {dvd_r[CTV_DW-2:0], 1'b0};
      q_r   <= {q_r[CTV_DW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: sv/capacitance_triple_validator.sv
// Capacitance triple validator.
// Input channel in_*: one word per raw charge measurement. in_tdata holds
// start_code and charge_ticks, in_tuser the timeout flag. Output channel out_*:
// exactly one result word per accepted input word. Config channel cfg_*: a
// register index and data, always ready; write only while the block is idle.
// Each measurement is converted to nF (current*16*ticks/(ref-start_mv),
// saturated to 32 bits); the third of a series runs the pairwise plausibility
// filter and reports the mean of the agreeing set.
// Sequencing: one measurement at a time, in_tready high only while idle. A
// shared shift-add multiplier and a restoring divider retire one bit per
// cycle. A held measurement runs the 10-bit start-voltage multiply, the
// 23-bit divide, the 16-bit value multiply and the 45-bit divide; a timeout
// or too small swing ends after the 23-bit divide; the last of a series adds
// three 7-bit pair products and, when all three agree, a 34-bit divide by
// three. The next word can be accepted in the cycle after the load at the
// earliest.
// Reset (rst_n synchronous, low) restores the register defaults, clears the
// session counters and the min/max record and starts a new series.
// A stalled receiver holds the result in the output register; the next word
// is accepted and processed, but its result waits until the slot frees.
module capacitance_triple_validator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // [9:0] start_code, [34:10] charge_ticks, rest zero
  input  logic [0:0]   in_tuser,   // [0] timed_out
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] capacitance_nf, [33:32] status, [35:34] series_index,
  // [36] outside_limits, [37] session_record, [40:38] size_class,
  // [56:41] passed_count, [72:57] failed_count, [88:73] total_count,
  // [120:89] max_nf, [152:121] min_nf, rest zero
  output logic [159:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import ctv_pkg::*;

  // configuration registers
  logic [15:0] current_ua_r;
  logic [12:0] ref_mv_r;
  logic [12:0] min_delta_r;
  logic [6:0]  plaus_pct_r;
  logic [31:0] cap_min_r;
  logic [31:0] cap_max_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_ua_r <= RST_CURRENT_UA;
      ref_mv_r     <= RST_REF_MV;
      min_delta_r  <= RST_MIN_DELTA;
      plaus_pct_r  <= RST_PLAUS_PCT;
      cap_min_r    <= RST_CAP_MIN;
      cap_max_r    <= RST_CAP_MAX;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CURRENT_UA: current_ua_r <= cfg_data[15:0];
        REG_REF_MV:     ref_mv_r     <= cfg_data[12:0];
        REG_MIN_DELTA:  min_delta_r  <= cfg_data[12:0];
        REG_PLAUS_PCT:  plaus_pct_r  <= cfg_data[6:0];
        REG_CAP_MIN:    cap_min_r    <= cfg_data;
        REG_CAP_MAX:    cap_max_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state
  ctv_state_t  state_r, state_nxt;
  ctv_status_t kind_r, kind_nxt;      // outcome of the current measurement
  logic [1:0]  pair_r, pair_nxt;      // which pair the agreement check is on
  logic [2:0]  agr_r, agr_nxt;        // {p12, p02, p01}
  logic [31:0] value_r, value_nxt;    // converted measurement
  logic [31:0] res_r, res_nxt;        // filtered result
  logic [12:0] delta_r, delta_nxt;

  // session state
  logic [1:0]  series_pos_r;
  logic [31:0] held0_r, held1_r;      // no reset: written before read
  logic [15:0] pass_total_r, fail_total_r, series_total_r;
  logic [31:0] rec_max_r, rec_min_r;

  // latched input word
  logic [24:0] ticks_r;
  logic        tout_r;

  // output register
  logic        out_valid_r;
  logic [31:0] o_cap_r;
  ctv_status_t o_status_r;
  logic [1:0]  o_idx_r;
  logic        o_oor_r, o_rec_r;
  logic [2:0]  o_size_r;
  logic [15:0] o_pass_r, o_fail_r, o_total_r;
  logic [31:0] o_max_r, o_min_r;

  // arithmetic units
  ctv_mul_req_t      mul_req;
  ctv_div_req_t      div_req;
  logic [31:0]       mul_a;
  logic [15:0]       mul_b;
  logic              mul_done;
  logic [CTV_DW-1:0] mul_prod;
  logic [CTV_DW-1:0] div_dvd;
  logic [12:0]       div_dvs;
  logic              div_done;
  logic [CTV_DW-1:0] div_q;

  ctv_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  ctv_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .done    (div_done),
    .quotient(div_q)
  );

  logic        in_acc;
  logic [1:0]  pos;
  logic [12:0] start_mv;
  logic [12:0] delta_c;
  logic [31:0] value_sat;
  logic [31:0] lo, hi, diff;
  logic [38:0] diff100;
  logic        pair_ok;
  logic [33:0] sum3;
  logic [32:0] pair_sum;
  logic        slot_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign pos       = (series_pos_r > LAST_POS) ? LAST_POS : series_pos_r;
  assign slot_free = !out_valid_r || out_tready;

  assign start_mv  = div_q[12:0];
  assign delta_c   = ref_mv_r - start_mv;
  assign value_sat = (|div_q[CTV_DW-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];

  // pair operands: 0 -> (v0,v1), 1 -> (v0,v2), 2 -> (v1,v2)
  always_comb begin
    logic [31:0] x, y;
    x = held0_r;
    y = held1_r;
    case (pair_r)
      2'd0:    begin x = held0_r; y = held1_r; end
      2'd1:    begin x = held0_r; y = value_r; end
      default: begin x = held1_r; y = value_r; end
    endcase
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
  end

  assign diff    = hi - lo;
  assign diff100 = {1'b0, diff, 6'b0} + {2'b0, diff, 5'b0} + {5'b0, diff, 2'b0};
  assign pair_ok = (lo != 32'd0) && (diff100 <= mul_prod[38:0]);

  assign sum3 = {2'b0, held0_r} + {2'b0, held1_r} + {2'b0, value_r};

  always_comb begin
    pair_sum = '0;
    if (agr_r == 3'b001)      pair_sum = {1'b0, held0_r} + {1'b0, held1_r};
    else if (agr_r == 3'b010) pair_sum = {1'b0, held0_r} + {1'b0, value_r};
    else                      pair_sum = {1'b0, held1_r} + {1'b0, value_r};
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    pair_nxt  = pair_r;
    agr_nxt   = agr_r;
    value_nxt = value_r;
    res_nxt   = res_r;
    delta_nxt = delta_r;
    mul_req   = '0;
    div_req   = '0;
    mul_a     = '0;
    mul_b     = '0;
    div_dvd   = '0;
    div_dvs   = ADC_FULL_SCALE;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mul_req.start = 1'b1;
          mul_req.nbits = 5'd10;
          mul_a         = {19'b0, ref_mv_r};
          mul_b         = {6'b0, in_tdata[9:0]};
          state_nxt     = S_SMV_MUL;
        end
      end
      S_SMV_MUL: begin
        if (mul_done) begin
          div_req.start = 1'b1;
          div_req.nbits = 6'd23;
          div_dvd       = {mul_prod[22:0], 25'b0};
          div_dvs       = ADC_FULL_SCALE;
          state_nxt     = S_SMV_DIV;
        end
      end
      S_SMV_DIV: begin
        if (div_done) begin
          delta_nxt = delta_c;
          if (tout_r || delta_c == 13'd0 || delta_c < min_delta_r) begin
            kind_nxt  = ST_INVALID;
            value_nxt = '0;
            state_nxt = S_FIN;
          end else begin
            mul_req.start = 1'b1;
            mul_req.nbits = 5'd16;
            mul_a         = {7'b0, ticks_r};
            mul_b         = current_ua_r;
            state_nxt     = S_VAL_MUL;
          end
        end
      end
      S_VAL_MUL: begin
        if (mul_done) begin
          // times 16, then align the 45-bit dividend to the top
          div_req.start = 1'b1;
          div_req.nbits = 6'd45;
          div_dvd       = {mul_prod[40:0], 7'b0};
          div_dvs       = delta_r;
          state_nxt     = S_VAL_DIV;
        end
      end
      S_VAL_DIV: begin
        if (div_done) begin
          value_nxt = value_sat;
          if (value_sat == 32'd0) begin
            kind_nxt  = ST_INVALID;
            state_nxt = S_FIN;
          end else if (pos < LAST_POS) begin
            kind_nxt  = ST_PENDING;
            state_nxt = S_FIN;
          end else begin
            pair_nxt  = 2'd0;
            agr_nxt   = '0;
            state_nxt = S_AGR_START;
          end
        end
      end
      S_AGR_START: begin
        mul_req.start = 1'b1;
        mul_req.nbits = 5'd7;
        mul_a         = lo;
        mul_b         = {9'b0, plaus_pct_r};
        state_nxt     = S_AGR_WAIT;
      end
      S_AGR_WAIT: begin
        if (mul_done) begin
          agr_nxt = agr_r;
          agr_nxt[pair_r] = pair_ok;
          if (pair_r == 2'd2) begin
            state_nxt = S_FIN;
            if (agr_nxt == 3'b111) begin
              div_req.start = 1'b1;
              div_req.nbits = 6'd34;
              div_dvd       = {sum3, 14'b0};
              div_dvs       = MEAN_OF_THREE;
              state_nxt     = S_MEAN_DIV;
            end else if (agr_nxt == 3'b001 || agr_nxt == 3'b010 || agr_nxt == 3'b100) begin
              kind_nxt = ST_PASS;
            end else begin
              kind_nxt = ST_SCATTER;
            end
          end else begin
            pair_nxt  = pair_r + 2'd1;
            state_nxt = S_AGR_START;
          end
        end
      end
      S_MEAN_DIV: begin
        if (div_done) begin
          res_nxt   = div_q[31:0];
          kind_nxt  = ST_PASS;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // a single agreeing pair: the mean is a shift
    if (state_r == S_AGR_WAIT && mul_done && pair_r == 2'd2 &&
        (agr_nxt == 3'b001 || agr_nxt == 3'b010 || agr_nxt == 3'b100)) begin
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= ST_PENDING;
      pair_r  <= '0;
      agr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      pair_r  <= pair_nxt;
      agr_r   <= agr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    delta_r <= delta_nxt;
    res_r   <= res_nxt;
    if (in_acc) begin
      ticks_r <= in_tdata[34:10];
      tout_r  <= in_tuser[0];
    end
  end

  // final bookkeeping, done while the word moves into the output register
  logic [31:0] r_fin;
  logic [15:0] pass_new, fail_new, total_new;
  logic [31:0] max_new, min_new;
  logic        flag, oor, rec;
  logic [2:0]  size;
  logic [31:0] cap_out;
  logic        fin_go;

  assign fin_go = (state_r == S_FIN) && slot_free;

  always_comb begin
    r_fin     = (agr_r == 3'b111) ? res_r : pair_sum[32:1];
    total_new = (pos == 2'd0) ? series_total_r + 16'd1 : series_total_r;
    pass_new  = pass_total_r;
    fail_new  = fail_total_r;
    max_new   = rec_max_r;
    min_new   = rec_min_r;
    flag      = 1'b0;
    oor       = 1'b0;
    rec       = 1'b0;
    size      = 3'd0;
    cap_out   = '0;
    case (kind_r)
      ST_PENDING: cap_out = value_r;
      ST_PASS: begin
        cap_out  = r_fin;
        pass_new = pass_total_r + 16'd1;
        if (r_fin > rec_max_r) begin max_new = r_fin; flag = 1'b1; end
        if (r_fin < rec_min_r) begin min_new = r_fin; flag = 1'b1; end
        oor = (r_fin < cap_min_r) || (r_fin > cap_max_r);
        rec = flag && !oor && (pass_new > 16'd1);
        if (r_fin < SIZE_LIM0)      size = 3'd0;
        else if (r_fin < SIZE_LIM1) size = 3'd1;
        else if (r_fin < SIZE_LIM2) size = 3'd2;
        else if (r_fin < SIZE_LIM3) size = 3'd3;
        else                        size = 3'd4;
      end
      default: fail_new = fail_total_r + 16'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_pos_r   <= '0;
      pass_total_r   <= '0;
      fail_total_r   <= '0;
      series_total_r <= '0;
      rec_max_r      <= '0;
      rec_min_r      <= '1;
      out_valid_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (fin_go) begin
        out_valid_r    <= 1'b1;
        pass_total_r   <= pass_new;
        fail_total_r   <= fail_new;
        series_total_r <= total_new;
        rec_max_r      <= max_new;
        rec_min_r      <= min_new;
        series_pos_r   <= (kind_r == ST_PENDING) ? pos + 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      if (kind_r == ST_PENDING && pos == 2'd0) held0_r <= value_r;
      if (kind_r == ST_PENDING && pos == 2'd1) held1_r <= value_r;
      o_cap_r    <= cap_out;
      o_status_r <= kind_r;
      o_idx_r    <= pos;
      o_oor_r    <= oor;
      o_rec_r    <= rec;
      o_size_r   <= size;
      o_pass_r   <= pass_new;
      o_fail_r   <= fail_new;
      o_total_r  <= total_new;
      o_max_r    <= max_new;
      o_min_r    <= min_new;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, o_min_r, o_max_r, o_total_r, o_fail_r, o_pass_r,
                       o_size_r, o_rec_r, o_oor_r, o_idx_r, o_status_r, o_cap_r};

  // checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("sequencer stayed idle after accepting a word");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    series_pos_r <= LAST_POS)
    else $error("series position out of range");

  a_pass_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_status_r == ST_PASS |-> o_cap_r != 32'd0)
    else $error("passed result is zero");

  a_flags_pass_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_status_r != ST_PASS |-> o_size_r == 3'd0 && !o_oor_r && !o_rec_r)
    else $error("pass-only flags set on a non-pass word");

  a_fin_one_cycle_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r && state_r == S_IDLE)
    else $error("result not registered after finish");

endmodule

// File: tb/ctv_checker.sv
`timescale 1ns / 1ps

module ctv_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [39:0]  in_tdata,
  input  logic [0:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [159:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending_count
);
  import ctv_pkg::*;

  typedef struct packed {
    logic [31:0] min_nf;
    logic [31:0] max_nf;
    logic [15:0] total;
    logic [15:0] failed;
    logic [15:0] passed;
    logic [2:0]  size_cls;
    logic        record;
    logic        oor;
    logic [1:0]  pos;
    logic [1:0]  status;
    logic [31:0] cap;
  } meas_word_t;

  logic [15:0] m_current;
  logic [12:0] m_ref, m_min_delta;
  logic [6:0]  m_pct;
  logic [31:0] m_cap_min, m_cap_max;
  logic [1:0]  m_pos;
  logic [31:0] m_held [2];
  logic [15:0] m_passed, m_failed, m_total;
  logic [31:0] m_rec_max, m_rec_min;

  meas_word_t expected_words[$];

  function automatic bit agrees(logic [31:0] a, logic [31:0] b);
    logic [63:0] lo, hi;
    lo = (a < b) ? 64'(a) : 64'(b);
    hi = (a < b) ? 64'(b) : 64'(a);
    if (lo == 0) return 0;
    return (hi - lo) * 100 <= m_pct * lo;
  endfunction

  function automatic logic [31:0] triple_mean(logic [31:0] v0, logic [31:0] v1,
                                              logic [31:0] v2);
    bit p01, p02, p12;
    p01 = agrees(v0, v1);
    p02 = agrees(v0, v2);
    p12 = agrees(v1, v2);
    if (p01 && p02 && p12) return 32'((64'(v0) + v1 + v2) / 3);
    if (p01 && !p12 && !p02) return 32'((64'(v0) + v1) / 2);
    if (p02 && !p01 && !p12) return 32'((64'(v0) + v2) / 2);
    if (p12 && !p01 && !p02) return 32'((64'(v1) + v2) / 2);
    return 0;
  endfunction

  task automatic predict_measurement(logic [9:0] code, logic [24:0] ticks, logic tout);
    logic [63:0] smv, delta, value;
    logic [31:0] r;
    bit flag;
    meas_word_t w;
    w = '0;
    w.pos = m_pos;
    smv = 64'(code) * m_ref / 1023;
    delta = 64'(m_ref) - smv;
    value = 0;
    if (m_pos == 0) m_total++;
    if (!tout && delta != 0 && delta >= m_min_delta) begin
      value = 64'(m_current) * 16 * ticks / delta;
      if (value > 64'hFFFF_FFFF) value = 64'hFFFF_FFFF;
    end
    if (value == 0) begin
      w.status = ST_INVALID;
      m_failed++;
      m_pos = 0;
    end else if (m_pos < LAST_POS) begin
      m_held[m_pos[0]] = value[31:0];
      w.cap = value[31:0];
      w.status = ST_PENDING;
      m_pos++;
    end else begin
      r = triple_mean(m_held[0], m_held[1], value[31:0]);
      m_pos = 0;
      if (r == 0) begin
        w.status = ST_SCATTER;
        m_failed++;
      end else begin
        flag = 0;
        w.status = ST_PASS;
        w.cap = r;
        m_passed++;
        if (r > m_rec_max) begin m_rec_max = r; flag = 1; end
        if (r < m_rec_min) begin m_rec_min = r; flag = 1; end
        w.oor = (r < m_cap_min || r > m_cap_max);
        w.record = flag && !w.oor && m_passed > 1;
        w.size_cls = (r < SIZE_LIM0) ? 3'd0 : (r < SIZE_LIM1) ? 3'd1 :
                     (r < SIZE_LIM2) ? 3'd2 : (r < SIZE_LIM3) ? 3'd3 : 3'd4;
      end
    end
    w.passed = m_passed;
    w.failed = m_failed;
    w.total = m_total;
    w.max_nf = m_rec_max;
    w.min_nf = m_rec_min;
    expected_words.push_back(w);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic compare_word(meas_word_t got);
    meas_word_t w;
    if (expected_words.size() == 0) begin
      report_mismatch("unexpected result word", 32'd1, 32'd0);
      return;
    end
    w = expected_words.pop_front();
    if (got.cap != w.cap) report_mismatch("capacitance_nf", got.cap, w.cap);
    if (got.status != w.status)
      report_mismatch("status", 32'(got.status), 32'(w.status));
    if (got.pos != w.pos) report_mismatch("series_index", 32'(got.pos), 32'(w.pos));
    if (got.oor != w.oor) report_mismatch("outside_limits", 32'(got.oor), 32'(w.oor));
    if (got.record != w.record)
      report_mismatch("session_record", 32'(got.record), 32'(w.record));
    if (got.size_cls != w.size_cls)
      report_mismatch("size_class", 32'(got.size_cls), 32'(w.size_cls));
    if (got.passed != w.passed)
      report_mismatch("passed_count", 32'(got.passed), 32'(w.passed));
    if (got.failed != w.failed)
      report_mismatch("failed_count", 32'(got.failed), 32'(w.failed));
    if (got.total != w.total)
      report_mismatch("total_count", 32'(got.total), 32'(w.total));
    if (got.max_nf != w.max_nf) report_mismatch("max_nf", got.max_nf, w.max_nf);
    if (got.min_nf != w.min_nf) report_mismatch("min_nf", got.min_nf, w.min_nf);
    if (out_tdata[159:153] != 7'd0)
      report_mismatch("pad bits", 32'(out_tdata[159:153]), 32'd0);
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      m_current = RST_CURRENT_UA;
      m_ref = RST_REF_MV;
      m_min_delta = RST_MIN_DELTA;
      m_pct = RST_PLAUS_PCT;
      m_cap_min = RST_CAP_MIN;
      m_cap_max = RST_CAP_MAX;
      m_pos = 0;
      m_held[0] = 0;
      m_held[1] = 0;
      m_passed = 0;
      m_failed = 0;
      m_total = 0;
      m_rec_max = 0;
      m_rec_min = '1;
      expected_words.delete();
    end else begin
      // result side first: a word cannot come out in the cycle its input goes in
      if (out_tvalid && out_tready) compare_word(out_tdata[152:0]);
      if (cfg_valid && cfg_ready) begin
        case (ctv_reg_t'(cfg_index))
          REG_CURRENT_UA: m_current = cfg_data[15:0];
          REG_REF_MV:     m_ref = cfg_data[12:0];
          REG_MIN_DELTA:  m_min_delta = cfg_data[12:0];
          REG_PLAUS_PCT:  m_pct = cfg_data[6:0];
          REG_CAP_MIN:    m_cap_min = cfg_data;
          REG_CAP_MAX:    m_cap_max = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_measurement(in_tdata[9:0], in_tdata[34:10], in_tuser[0]);
    end
    pending_count = expected_words.size();
  end

endmodule

// File: tb/capacitance_triple_validator_tb.sv
`timescale 1ns / 1ps

module capacitance_triple_validator_tb;
  import ctv_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;   // [9:0] start_code, [34:10] charge_ticks
  logic [0:0]   in_tuser = '0;   // [0] timed_out
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [159:0] out_tdata;       // cap, status, index, flags, counters, record
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  int fail_count, pending_count;
  int sender_idle_pct, receiver_stall_pct;
  int idle_cycles;

  // held values of the current series, for building agreeing triples
  logic [9:0]  series_code;
  logic [24:0] series_ticks;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  capacitance_triple_validator uut (.*);

  ctv_checker checker_i (.*);

  // receiver: random stall as set by the current phase
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("capacitance_triple_validator test failed");
      $finish;
    end
  end

  // in_tvalid stays high after the handshake; the block drops in_tready while
  // busy, and the next send or settle replaces or clears it
  task automatic send_measurement(logic [9:0] code, logic [24:0] ticks, logic tout);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {5'd0, ticks, code};
    in_tuser <= tout;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(ctv_reg_t idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // drain results, then let the block finish any in-flight work
  task automatic settle;
    in_tvalid <= 0;
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  // one random measurement: mostly agreeing series, some noise
  task automatic random_measurement(int pos);
    int kind;
    logic [24:0] t;
    kind = $urandom_range(99);
    if (pos == 0 || kind < 10) begin
      series_code = 10'($urandom_range(600));
      series_ticks = ($urandom_range(9) == 0) ? 25'($urandom) : 25'($urandom_range(5000, 1));
    end
    if (kind < 6)
      send_measurement(10'($urandom), 25'($urandom), 1'($urandom_range(1)));
    else if (kind < 10)
      send_measurement(10'($urandom_range(1023, 990)), 25'($urandom), 0);
    else begin
      t = 25'(series_ticks + $urandom_range(series_ticks / 8 + 1) - series_ticks / 16);
      send_measurement(series_code, t, ($urandom_range(49) == 0));
    end
  endtask

  initial begin
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes, timeout, tiny swing, saturation, scatter, passes
    send_measurement(0, 0, 0);
    send_measurement(0, 1000, 1);
    send_measurement(1023, 1000, 0);
    send_measurement(1000, 1000, 0);
    send_measurement(0, 25'h1FF_FFFF, 0);
    send_measurement(0, 25'h1FF_FFFF, 0);
    send_measurement(0, 25'h1FF_FFFF, 0);
    send_measurement(10, 100, 0);
    send_measurement(10, 5000, 0);
    send_measurement(10, 200, 0);
    send_measurement(10, 100, 0);
    send_measurement(10, 110, 0);
    send_measurement(10, 300, 0);
    send_measurement(10, 1, 0);
    send_measurement(10, 1, 0);
    send_measurement(10, 1, 0);
    send_measurement(512, 2000, 0);
    send_measurement(512, 2050, 0);
    send_measurement(512, 1990, 0);
    send_measurement(20, 10, 0);
    send_measurement(0, 100, 1);
    settle();

    // extreme register settings
    write_reg(REG_CURRENT_UA, 65535);
    write_reg(REG_REF_MV, 5000);
    write_reg(REG_MIN_DELTA, 0);
    write_reg(REG_PLAUS_PCT, 100);
    write_reg(REG_CAP_MIN, 0);
    write_reg(REG_CAP_MAX, 32'hFFFF_FFFF);
    send_measurement(1023, 50, 0);
    send_measurement(1022, 50, 0);
    send_measurement(1022, 99, 0);
    send_measurement(1022, 60, 0);
    send_measurement(0, 25'h1FF_FFFF, 0);
    settle();
    write_reg(REG_REF_MV, 0);
    send_measurement(0, 100, 0);
    settle();
    write_reg(REG_CURRENT_UA, 1);
    write_reg(REG_REF_MV, 1);
    write_reg(REG_MIN_DELTA, 5000);
    write_reg(REG_PLAUS_PCT, 0);
    send_measurement(0, 100, 0);
    settle();

    // random phases: each pairs a register setting with an idling pattern
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_CURRENT_UA, (ph % 4 == 3) ? 65535 : $urandom_range(5000, 1));
      write_reg(REG_REF_MV, (ph == 5) ? 5000 : $urandom_range(5000, 700));
      write_reg(REG_MIN_DELTA, $urandom_range(80));
      write_reg(REG_PLAUS_PCT, (ph == 2) ? 0 : (ph == 6) ? 100 : $urandom_range(30));
      write_reg(REG_CAP_MIN, $urandom_range(50000));
      write_reg(REG_CAP_MAX, (ph == 7) ? 32'hFFFF_FFFF : $urandom_range(2000000, 50000));
      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
        default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
      endcase
      for (int k = 0; k < 66; k++) random_measurement(k % 3);
      settle();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
    end

    if (fail_count == 0)
      $display("capacitance_triple_validator test passed");
    else
      $display("capacitance_triple_validator test failed");
    $finish;
  end

endmodule
